// ===== hw/rtl/sha256_hash_engine_top_defines.svh =====
// assertion macros used by the hash engine controller
`ifndef SHA256_HASH_ENGINE_TOP_DEFINES_SVH
`define SHA256_HASH_ENGINE_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SHE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define SHE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/she_pkg.sv =====
// shared types, constants and functions of the hash engine
package she_pkg;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] POS_LAST = 6'd63;
    localparam logic [5:0] POS_LEN  = 6'd56;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_ROUND [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_WAIT_OUT
    } t_she_state;

    typedef struct packed {
        logic load_byte;
        logic pad_byte;
        logic pad_mark;
        logic put_len;
        logic init_vars;
        logic round;
        logic add_hash;
        logic capture;
    } t_dp_cmd;

    typedef struct packed {
        logic [5:0] pos;
        logic       round_last;
        logic       out_busy;
    } t_dp_status;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
        return (v >> n) | (v << (32 - n));
    endfunction

endpackage

// ===== hw/rtl/sha256_hash_engine_top.sv =====
// SHA-256 engine taking one message byte per item and giving eight digest word items.
// Message bytes are taken while the engine is idle; the 64th byte of each block starts
// 64 rounds through the single round unit at one per cycle, then the hash update, with
// the input stalled. An end item pads one byte per cycle up to the length field
// (at most 64 bytes over two passes when the tail is too long); each pass ends with a
// step that closes the block and loads the working variables, then a compression.
// After that the digest moves to an eight-word output buffer and the engine
// re-initialises; the input stays stalled from an end item until then. Digest words
// drain from that buffer while new message bytes are taken; a following digest is
// held in the engine, with the input stalled, until the previous one has been fully
// delivered.
module sha256_hash_engine_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  she_pkg::t_in_item   i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output she_pkg::t_out_item  o_out_data,
    input  logic                i_out_stall
);

    she_pkg::t_dp_cmd    cmd;
    she_pkg::t_dp_status status;

    she_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_in_data.kind),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    she_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data_byte (i_in_data.data_byte),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

// ===== hw/rtl/she_datapath.sv =====
// block buffer, round unit, hash words and digest output buffer
module she_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [7:0]            i_data_byte,
    input  she_pkg::t_dp_cmd      i_cmd,
    output she_pkg::t_dp_status   o_status,
    output logic                  o_out_valid,
    output she_pkg::t_out_item    o_out_data,
    input  logic                  i_out_stall
);

    logic [31:0] r_hash [8];
    logic [31:0] r_var  [8];
    logic [31:0] r_buf  [16];
    logic [31:0] r_out_word [8];
    logic [63:0] r_len;
    logic [5:0]  r_pos;
    logic [5:0]  r_round;
    logic [2:0]  r_out_idx;
    logic        r_out_valid;

    logic [7:0]  n_byte;
    logic [31:0] n_word;
    logic [31:0] n_sched;
    logic [31:0] n_t1;
    logic [31:0] n_t2;
    logic        out_take;

    // byte placement, big-endian within each word; a word is cleared on its first byte
    always_comb begin
        n_byte = i_cmd.load_byte ? i_data_byte : (i_cmd.pad_mark ? she_pkg::PAD_MARK : 8'd0);
        n_word = ((r_pos[1:0] == 2'd0) ? 32'd0 : r_buf[r_pos[5:2]])
               | ({24'd0, n_byte} << {2'd3 - r_pos[1:0], 3'b000});
    end

    // one compression round and the next schedule word
    always_comb begin
        logic [31:0] big1;
        logic [31:0] choose;
        logic [31:0] big0;
        logic [31:0] major;
        logic [31:0] sig0;
        logic [31:0] sig1;
        big1   = she_pkg::rotr(r_var[4], 6) ^ she_pkg::rotr(r_var[4], 11)
               ^ she_pkg::rotr(r_var[4], 25);
        choose = (r_var[4] & r_var[5]) ^ (~r_var[4] & r_var[6]);
        n_t1   = r_var[7] + big1 + choose + she_pkg::K_ROUND[r_round] + r_buf[0];
        big0   = she_pkg::rotr(r_var[0], 2) ^ she_pkg::rotr(r_var[0], 13)
               ^ she_pkg::rotr(r_var[0], 22);
        major  = (r_var[0] & r_var[1]) ^ (r_var[0] & r_var[2]) ^ (r_var[1] & r_var[2]);
        n_t2   = big0 + major;
        sig0   = she_pkg::rotr(r_buf[1], 7) ^ she_pkg::rotr(r_buf[1], 18) ^ (r_buf[1] >> 3);
        sig1   = she_pkg::rotr(r_buf[14], 17) ^ she_pkg::rotr(r_buf[14], 19)
               ^ (r_buf[14] >> 10);
        n_sched = sig1 + r_buf[9] + sig0 + r_buf[0];
    end

    assign out_take = r_out_valid && !i_out_stall;

    // buffer doubles as the schedule window during rounds
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte || i_cmd.pad_byte) begin
            r_buf[r_pos[5:2]] <= n_word;
        end
        if (i_cmd.put_len) begin
            r_buf[14] <= r_len[63:32];
            r_buf[15] <= r_len[31:0];
        end
        if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) begin
                r_buf[i] <= r_buf[i + 1];
            end
            r_buf[15] <= n_sched;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init_vars) begin
            for (int i = 0; i < 8; i++) begin
                r_var[i] <= r_hash[i];
            end
        end else if (i_cmd.round) begin
            r_var[7] <= r_var[6];
            r_var[6] <= r_var[5];
            r_var[5] <= r_var[4];
            r_var[4] <= r_var[3] + n_t1;
            r_var[3] <= r_var[2];
            r_var[2] <= r_var[1];
            r_var[1] <= r_var[0];
            r_var[0] <= n_t1 + n_t2;
        end
        if (i_cmd.capture) begin
            for (int i = 0; i < 8; i++) begin
                r_out_word[i] <= r_hash[i];
            end
        end else if (out_take) begin
            for (int i = 0; i < 7; i++) begin
                r_out_word[i] <= r_out_word[i + 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_hash[i] <= she_pkg::H_INIT[i];
            end
            r_len       <= 64'd0;
            r_pos       <= 6'd0;
            r_round     <= 6'd0;
            r_out_idx   <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_byte || i_cmd.pad_byte) begin
                r_pos <= r_pos + 6'd1;
            end
            if (i_cmd.load_byte) begin
                r_len <= r_len + 64'd8;
            end
            if (i_cmd.round) begin
                r_round <= r_round + 6'd1;
            end
            if (i_cmd.add_hash) begin
                for (int i = 0; i < 8; i++) begin
                    r_hash[i] <= r_hash[i] + r_var[i];
                end
            end
            if (i_cmd.capture) begin
                for (int i = 0; i < 8; i++) begin
                    r_hash[i] <= she_pkg::H_INIT[i];
                end
                r_len       <= 64'd0;
                r_pos       <= 6'd0;
                r_out_idx   <= 3'd0;
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_idx <= r_out_idx + 3'd1;
                if (r_out_idx == 3'd7) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    assign o_status.pos        = r_pos;
    assign o_status.round_last = (r_round == 6'd63);
    assign o_status.out_busy   = r_out_valid;

    assign o_out_valid            = r_out_valid;
    assign o_out_data.digest_word = r_out_word[0];
    assign o_out_data.word_index  = r_out_idx;
    assign o_out_data.last_word   = (r_out_idx == 3'd7);

endmodule

// ===== hw/rtl/she_controller.sv =====
// sequencer for byte loading, padding, compression and digest hand-off
`include "sha256_hash_engine_top_defines.svh"

module she_controller (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_kind,
    input  she_pkg::t_dp_status  i_status,
    output logic                 o_in_stall,
    output she_pkg::t_dp_cmd     o_cmd
);

    she_pkg::t_she_state r_state;
    she_pkg::t_she_state n_state;
    logic r_two;
    logic n_two;
    logic r_final;
    logic n_final;
    logic pad_done;

    // padding stops at the wrap when a second block is needed, else at the length field
    assign pad_done = r_two ? (i_status.pos == 6'd0) : (i_status.pos == she_pkg::POS_LEN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= she_pkg::ST_IDLE;
            r_two   <= 1'b0;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            r_two   <= n_two;
            r_final <= n_final;
        end
    end

    always_comb begin
        n_state = r_state;
        n_two   = r_two;
        n_final = r_final;
        case (r_state)
            she_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_kind == she_pkg::KIND_BYTE) begin
                        if (i_status.pos == she_pkg::POS_LAST) begin
                            n_state = she_pkg::ST_ROUND;
                        end
                    end else begin
                        n_state = she_pkg::ST_PAD;
                        n_two   = (i_status.pos >= she_pkg::POS_LEN);
                        n_final = 1'b1;
                    end
                end
            end
            she_pkg::ST_PAD: begin
                if (pad_done) begin
                    n_state = she_pkg::ST_ROUND;
                end
            end
            she_pkg::ST_ROUND: begin
                if (i_status.round_last) begin
                    n_state = she_pkg::ST_ADD;
                end
            end
            she_pkg::ST_ADD: begin
                if (r_two) begin
                    n_state = she_pkg::ST_PAD;
                    n_two   = 1'b0;
                end else if (r_final) begin
                    n_state = she_pkg::ST_WAIT_OUT;
                end else begin
                    n_state = she_pkg::ST_IDLE;
                end
            end
            she_pkg::ST_WAIT_OUT: begin
                if (!i_status.out_busy) begin
                    n_state = she_pkg::ST_IDLE;
                    n_final = 1'b0;
                end
            end
            default: begin
                n_state = she_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            she_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_kind == she_pkg::KIND_BYTE) begin
                        o_cmd.load_byte = 1'b1;
                        o_cmd.init_vars = (i_status.pos == she_pkg::POS_LAST);
                    end else begin
                        o_cmd.pad_byte = 1'b1;
                        o_cmd.pad_mark = 1'b1;
                    end
                end
            end
            she_pkg::ST_PAD: begin
                if (pad_done) begin
                    o_cmd.init_vars = 1'b1;
                    o_cmd.put_len   = !r_two;
                end else begin
                    o_cmd.pad_byte = 1'b1;
                end
            end
            she_pkg::ST_ROUND: begin
                o_cmd.round = 1'b1;
            end
            she_pkg::ST_ADD: begin
                o_cmd.add_hash = 1'b1;
            end
            she_pkg::ST_WAIT_OUT: begin
                o_cmd.capture = !i_status.out_busy;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    `SHE_ASSERT_IMPL(a_capture_free, i_clk, i_rst_n, o_cmd.capture, !i_status.out_busy, "digest captured over undrained output")
    `SHE_ASSERT_NEXT(a_rounds_run, i_clk, i_rst_n, o_cmd.round && !i_status.round_last, o_cmd.round, "round sequence broken")
    `SHE_ASSERT_NEXT(a_add_after_last, i_clk, i_rst_n, o_cmd.round && i_status.round_last, o_cmd.add_hash, "hash update missing after last round")
    `SHE_ASSERT_IMPL(a_len_at_field, i_clk, i_rst_n, o_cmd.put_len, i_status.pos == she_pkg::POS_LEN, "length written at wrong position")

endmodule

// ===== bench/tb_sha256_hash_engine_top.sv =====
// testbench for the byte-fed sha-256 engine: own digest model, random messages and stalls
`timescale 1ns / 1ps

module tb_sha256_hash_engine_top;

    localparam int TOTAL_ITEMS  = 460;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int SETTLE_LEN   = 300;
    localparam int IDLE_PERCENT = 27;

    localparam logic [31:0] IV_WORDS [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    she_pkg::t_in_item  i_in_data   = '0;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    she_pkg::t_out_item o_out_data;

    // digest model state
    logic [31:0]        hash_state [8];
    logic [31:0]        msg_block [16];
    logic [63:0]        msg_bits;
    she_pkg::t_out_item digest_queue [$];

    int  err_count   = 0;
    int  items_sent  = 0;
    int  hold_left   = 0;
    bit  calm        = 1'b0;

    sha256_hash_engine_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
        logic [63:0] twice;
        twice = {v, v} >> n;
        return twice[31:0];
    endfunction

    function automatic void restart_digest();
        for (int k = 0; k < 8; k++) hash_state[k] = IV_WORDS[k];
        for (int k = 0; k < 16; k++) msg_block[k] = '0;
        msg_bits = '0;
    endfunction

    function automatic void compress_into_hash();
        logic [31:0] sched [64];
        logic [31:0] va, vb, vc, vd, ve, vf, vg, vh;
        logic [31:0] t1, t2, sg0, sg1;
        for (int t = 0; t < 16; t++) sched[t] = msg_block[t];
        for (int t = 16; t < 64; t++) begin
            sg0 = ror32(sched[t-15], 7) ^ ror32(sched[t-15], 18) ^ (sched[t-15] >> 3);
            sg1 = ror32(sched[t-2], 17) ^ ror32(sched[t-2], 19) ^ (sched[t-2] >> 10);
            sched[t] = sg1 + sched[t-7] + sg0 + sched[t-16];
        end
        {va, vb, vc, vd} = {hash_state[0], hash_state[1], hash_state[2], hash_state[3]};
        {ve, vf, vg, vh} = {hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
        for (int t = 0; t < 64; t++) begin
            t1 = vh + (ror32(ve, 6) ^ ror32(ve, 11) ^ ror32(ve, 25))
                 + ((ve & vf) ^ (~ve & vg)) + ROUND_K[t] + sched[t];
            t2 = (ror32(va, 2) ^ ror32(va, 13) ^ ror32(va, 22))
                 + ((va & vb) ^ (va & vc) ^ (vb & vc));
            vh = vg; vg = vf; vf = ve; ve = vd + t1;
            vd = vc; vc = vb; vb = va; va = t1 + t2;
        end
        hash_state[0] += va; hash_state[1] += vb;
        hash_state[2] += vc; hash_state[3] += vd;
        hash_state[4] += ve; hash_state[5] += vf;
        hash_state[6] += vg; hash_state[7] += vh;
    endfunction

    function automatic void place_byte(input int pos, input logic [7:0] b);
        msg_block[pos / 4][(3 - pos % 4) * 8 +: 8] = b;
    endfunction

    function automatic void absorb_byte(input logic [7:0] b);
        int pos;
        pos = int'(msg_bits[8:3]);
        place_byte(pos, b);
        msg_bits += 64'd8;
        if (pos == 63) compress_into_hash();
    endfunction

    // standard padding, one or two final blocks, then eight digest word items
    function automatic void close_message();
        int pos;
        she_pkg::t_out_item word;
        pos = int'(msg_bits[8:3]);
        place_byte(pos, 8'h80);
        pos++;
        if (pos > 56) begin
            while (pos < 64) begin
                place_byte(pos, 8'h00);
                pos++;
            end
            compress_into_hash();
            pos = 0;
        end
        while (pos < 56) begin
            place_byte(pos, 8'h00);
            pos++;
        end
        msg_block[14] = msg_bits[63:32];
        msg_block[15] = msg_bits[31:0];
        compress_into_hash();
        for (int k = 0; k < 8; k++) begin
            word.digest_word = hash_state[k];
            word.word_index  = 3'(k);
            word.last_word   = (k == 7);
            digest_queue.push_back(word);
        end
        restart_digest();
    endfunction

    // receiver side: random stalls, quiet stretches and one long hold-off
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall = 1'b1;
            hold_left = hold_left - 1;
        end else if (calm) begin
            i_out_stall = 1'b0;
        end else begin
            i_out_stall = ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    always @(posedge i_clk) begin : check_digest
        she_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (digest_queue.size() == 0) begin
                $display("%0t: unexpected digest item %h", $time, o_out_data);
                err_count++;
            end else begin
                want = digest_queue.pop_front();
                if (o_out_data.digest_word !== want.digest_word) begin
                    $display("%0t: digest_word expected %h actual %h",
                             $time, want.digest_word, o_out_data.digest_word);
                    err_count++;
                end
                if (o_out_data.word_index !== want.word_index) begin
                    $display("%0t: word_index expected %0d actual %0d",
                             $time, want.word_index, o_out_data.word_index);
                    err_count++;
                end
                if (o_out_data.last_word !== want.last_word) begin
                    $display("%0t: last_word expected %b actual %b",
                             $time, want.last_word, o_out_data.last_word);
                    err_count++;
                end
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input logic kind, input logic [7:0] b);
        while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data.kind      = kind;
        i_in_data.data_byte = b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (kind == she_pkg::KIND_BYTE) absorb_byte(b);
        else close_message();
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_message(input int len);
        for (int k = 0; k < len; k++) begin
            send_item(she_pkg::KIND_BYTE, 8'($urandom_range(255)));
        end
        send_item(she_pkg::KIND_END, 8'($urandom_range(255)));
    endtask

    task automatic test_short_messages();
        send_item(she_pkg::KIND_END, 8'hff);        // empty message, ignored byte all ones
        send_item(she_pkg::KIND_BYTE, 8'h00);
        send_item(she_pkg::KIND_END, 8'h00);
        send_item(she_pkg::KIND_BYTE, 8'hff);
        send_item(she_pkg::KIND_END, 8'h5a);
        send_item(she_pkg::KIND_BYTE, 8'h61);
        send_item(she_pkg::KIND_BYTE, 8'h62);
        send_item(she_pkg::KIND_BYTE, 8'h63);
        send_item(she_pkg::KIND_END, 8'ha5);
        send_item(she_pkg::KIND_BYTE, 8'h55);
        send_item(she_pkg::KIND_BYTE, 8'haa);
        send_item(she_pkg::KIND_END, 8'h00);
        send_item(she_pkg::KIND_END, 8'h00);        // back-to-back empty message
    endtask

    // lengths around the point where the length field no longer fits
    task automatic test_padding_boundaries();
        send_message(55);
        send_message(56);
        send_message(63);
        send_message(64);
    endtask

    // receiver holds off while the sender keeps offering items
    task automatic test_output_hold_off();
        hold_left = HOLD_CYCLES;
        send_message(3);
        send_message(5);
        send_message(2);
        send_message(0);
    endtask

    task automatic test_random_messages();
        int pick;
        int len;
        int first_items;
        first_items = items_sent;
        calm = 1'b1;
        while (items_sent < TOTAL_ITEMS) begin
            if (items_sent - first_items > 120) calm = 1'b0;
            pick = $urandom_range(99);
            if (pick < 80) len = $urandom_range(24);
            else if (pick < 95) len = $urandom_range(72, 48);
            else len = $urandom_range(140, 100);
            // keep the last message within the item budget
            if (len > TOTAL_ITEMS - items_sent - 1) len = TOTAL_ITEMS - items_sent - 1;
            send_message(len);
        end
        calm = 1'b0;
    endtask

    task automatic wait_for_digests();
        int waited;
        i_in_valid = 1'b0;
        waited = 0;
        while (digest_queue.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (digest_queue.size() != 0) begin
            $display("%0t: %0d digest items never arrived", $time, digest_queue.size());
            err_count++;
        end
        repeat (SETTLE_LEN) @(posedge i_clk);
    endtask

    initial begin
        restart_digest();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_short_messages();
        test_padding_boundaries();
        test_output_hold_off();
        test_random_messages();
        wait_for_digests();
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("%0t: run timed out", $time);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sha256_hash_engine_top.f =====
+incdir+hw/rtl
hw/rtl/she_pkg.sv
hw/rtl/she_datapath.sv
hw/rtl/she_controller.sv
hw/rtl/sha256_hash_engine_top.sv
bench/tb_sha256_hash_engine_top.sv
